/* rtl/point_fuse_within_tolerance_macros.svh */
// Assertion helpers shared by the RTL; all checks run on clk and are held off in reset.
`ifndef POINT_FUSE_WITHIN_TOLERANCE_MACROS_SVH
`define POINT_FUSE_WITHIN_TOLERANCE_MACROS_SVH

// Same-cycle implication.
`define PFWT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfwt check failed");

// Next-cycle implication.
`define PFWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfwt check failed");

`endif

/* rtl/pfwt_pkg.sv */
package pfwt_pkg;

    localparam int COORD_W  = 32;
    localparam int BUCKET_W = 32;
    localparam int TOL_W    = 31;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RECORD
    } state_t;

endpackage

/* rtl/pfwt_if.sv */
interface pfwt_in_if
    import pfwt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                first_of_set;
    logic [BUCKET_W-1:0] bucket_code;
    coord_t              x_coord;
    coord_t              y_coord;
    coord_t              z_coord;

    modport source (
        output valid, first_of_set, bucket_code, x_coord, y_coord, z_coord,
        input  ready
    );
    modport sink (
        input  valid, first_of_set, bucket_code, x_coord, y_coord, z_coord,
        output ready
    );
endinterface

interface pfwt_out_if #(
    parameter int ID_WIDTH = 24
);
    logic                valid;
    logic                ready;
    logic [ID_WIDTH-1:0] point_id;
    logic                is_new;
    logic                window_overflow;

    modport source (
        output valid, point_id, is_new, window_overflow,
        input  ready
    );
    modport sink (
        input  valid, point_id, is_new, window_overflow,
        output ready
    );
endinterface

/* rtl/pfwt_ram.sv */
module pfwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/pfwt_cmp.sv */
// Per-axis closeness: |a - b| < tol on all three axes, differences taken at 33 bits.
module pfwt_cmp
    import pfwt_pkg::*;
(
    input  point_t           pt,
    input  point_t           entry,
    input  logic [TOL_W-1:0] tol,
    output logic             hit
);

    function automatic logic axis_close(input coord_t a, input coord_t b,
                                        input logic [TOL_W-1:0] t);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        mag;
        d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        mag = d[COORD_W] ? (COORD_W+1)'(-d) : d;
        return mag < {{(COORD_W+1-TOL_W){1'b0}}, t};
    endfunction

    assign hit = axis_close(pt.x, entry.x, tol)
              && axis_close(pt.y, entry.y, tol)
              && axis_close(pt.z, entry.z, tol);

endmodule

/* rtl/point_fuse_within_tolerance.sv */
// Point welding with a per-axis tolerance. Points arrive sorted by bucket code; each one is
// compared, newest first, against a window of the last WINDOW_DEPTH points of the current
// bucket run, held in a small RAM together with the ids they were given. The first stored
// point whose x, y and z each lie strictly closer than the tolerance gives its id and the
// result reports is_new = 0; otherwise the point takes the next fresh id (saturating at
// all ones). first_of_set empties the window and restarts ids at 0; a change of bucket code
// empties the window only. window_overflow reports that the run had already dropped old
// points before this one was compared. The sequencer takes the transfer while idle, then
// scans one window entry per cycle through a single shared compare unit fed by the RAM's
// registered read port, then records the point once the output register is free. A match
// stops the scan early. The input is ready only while the sequencer is idle; a finished
// result sits in an output register, so the next point is taken while the previous result
// waits. The tolerance register may be written only while the block is idle.
module point_fuse_within_tolerance
    import pfwt_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16,
    parameter int ID_WIDTH     = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TOL_W-1:0]  cfg_wdata,
    pfwt_in_if.sink           points,
    pfwt_out_if.source        results
);

    `include "point_fuse_within_tolerance_macros.svh"

    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int ENTRY_W = 3 * COORD_W + ID_WIDTH;
    localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0]   FULL_FILL  = FILL_W'(WINDOW_DEPTH);
    localparam logic [ID_WIDTH-1:0] ID_MAX     = {ID_WIDTH{1'b1}};

    // Sequencer and window bookkeeping
    state_t              state_reg,   state_next;
    logic [TOL_W-1:0]    tol_reg;
    logic [FILL_W-1:0]   fill_reg,    fill_next;
    logic [IDX_W-1:0]    head_reg,    head_next;
    logic                ovf_reg,     ovf_next;
    logic [BUCKET_W-1:0] bucket_reg,  bucket_next;
    logic [ID_WIDTH-1:0] fresh_reg,   fresh_next;
    logic [IDX_W-1:0]    ptr_reg,     ptr_next;
    logic [FILL_W-1:0]   k_reg,       k_next;
    logic                rd_vld_reg,  rd_vld_next;
    logic                fused_reg,   fused_next;
    logic [ID_WIDTH-1:0] hit_id_reg,  hit_id_next;
    point_t              pt_reg,      pt_next;

    // Output register
    logic                out_vld_reg, out_vld_next;
    logic [ID_WIDTH-1:0] out_id_reg,  out_id_next;
    logic                out_new_reg, out_new_next;
    logic                out_ovf_reg, out_ovf_next;

    logic                take;
    logic                out_free;
    logic                new_run;
    logic [IDX_W-1:0]    head_eff;
    logic                issue;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [ID_WIDTH-1:0] rec_id;
    point_t              entry;
    logic                cmp_hit;

    assign take     = points.valid && points.ready;
    assign out_free = !out_vld_reg || results.ready;
    assign new_run  = points.first_of_set || (points.bucket_code != bucket_reg);
    assign head_eff = new_run ? '0 : head_reg;
    assign issue    = (k_reg < fill_reg);
    assign rec_id   = fused_reg ? hit_id_reg : fresh_reg;

    assign points.ready            = (state_reg == ST_IDLE);
    assign results.valid           = out_vld_reg;
    assign results.point_id        = out_id_reg;
    assign results.is_new          = out_new_reg;
    assign results.window_overflow = out_ovf_reg;

    // Window store: {id, x, y, z} per entry
    assign ram_wdata = {rec_id, pt_reg.x, pt_reg.y, pt_reg.z};
    assign entry     = ram_rdata[3*COORD_W-1:0];

    pfwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    pfwt_cmp u_cmp (
        .pt    (pt_reg),
        .entry (entry),
        .tol   (tol_reg),
        .hit   (cmp_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tol_reg     <= '0;
            fill_reg    <= '0;
            head_reg    <= '0;
            ovf_reg     <= 1'b0;
            bucket_reg  <= '0;
            fresh_reg   <= '0;
            k_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            fused_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            ovf_reg     <= ovf_next;
            bucket_reg  <= bucket_next;
            fresh_reg   <= fresh_next;
            k_reg       <= k_next;
            rd_vld_reg  <= rd_vld_next;
            fused_reg   <= fused_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        hit_id_reg  <= hit_id_next;
        pt_reg      <= pt_next;
        out_id_reg  <= out_id_next;
        out_new_reg <= out_new_next;
        out_ovf_reg <= out_ovf_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        head_next    = head_reg;
        ovf_next     = ovf_reg;
        bucket_next  = bucket_reg;
        fresh_next   = fresh_reg;
        ptr_next     = ptr_reg;
        k_next       = k_reg;
        rd_vld_next  = 1'b0;
        fused_next   = fused_reg;
        hit_id_next  = hit_id_reg;
        pt_next      = pt_reg;
        ram_we       = 1'b0;
        out_vld_next = out_vld_reg && !results.ready;
        out_id_next  = out_id_reg;
        out_new_next = out_new_reg;
        out_ovf_next = out_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    // Open a new run if asked or if the bucket moved on; start the scan
                    // one slot behind the write head.
                    pt_next     = '{x: points.x_coord, y: points.y_coord, z: points.z_coord};
                    bucket_next = points.bucket_code;
                    if (new_run)
                    begin
                        fill_next = '0;
                        head_next = '0;
                        ovf_next  = 1'b0;
                    end
                    if (points.first_of_set)
                    begin
                        fresh_next = '0;
                    end
                    ptr_next   = (head_eff == '0) ? LAST_IDX : head_eff - 1'b1;
                    k_next     = '0;
                    fused_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle, walking back; compare the entry read last cycle.
                if (issue)
                begin
                    ptr_next    = (ptr_reg == '0) ? LAST_IDX : ptr_reg - 1'b1;
                    k_next      = k_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg && cmp_hit)
                begin
                    fused_next  = 1'b1;
                    hit_id_next = ram_rdata[ENTRY_W-1 -: ID_WIDTH];
                    state_next  = ST_RECORD;
                end
                else if (!issue)
                begin
                    state_next = ST_RECORD;
                end
            end

            ST_RECORD:
            begin
                // Hold until the output register is free, then write the window and report.
                if (out_free)
                begin
                    ram_we       = 1'b1;
                    head_next    = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    if (fill_reg == FULL_FILL)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (!fused_reg && (fresh_reg != ID_MAX))
                    begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                    out_vld_next = 1'b1;
                    out_id_next  = rec_id;
                    out_new_next = !fused_reg;
                    out_ovf_next = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Input is taken only by an idle sequencer.
    `PFWT_ASSERT_NOW(a_ready_idle, points.ready, state_reg == ST_IDLE)
    // A free output slot in the record step always yields a result next cycle.
    `PFWT_ASSERT_NEXT(a_record_out, (state_reg == ST_RECORD) && out_free, results.valid)
    // Overflow is only flagged once the window has filled.
    `PFWT_ASSERT_NOW(a_ovf_full, ovf_reg, fill_reg == FULL_FILL)

endmodule

/* tb/sv/point_fuse_within_tolerance_test.sv */
`timescale 1ns / 100ps

module point_fuse_within_tolerance_test;
    import pfwt_pkg::*;

    localparam int WINDOW_DEPTH = 16;
    localparam int ID_WIDTH     = 24;
    localparam int RANDOM_ITEMS = 200;   // per tolerance setting

    // One expected result per accepted point.
    typedef struct packed {
        logic [ID_WIDTH-1:0] point_id;
        logic                is_new;
        logic                window_overflow;
    } weld_result_t;

    logic clk;
    logic rst_n;
    logic             cfg_we;
    logic [TOL_W-1:0] cfg_wdata;

    pfwt_in_if                        points_if ();
    pfwt_out_if #(.ID_WIDTH(ID_WIDTH)) results_if ();

    point_fuse_within_tolerance #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ID_WIDTH     (ID_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .points    (points_if),
        .results   (results_if)
    );

    // Expected results, oldest first, and the mismatch count.
    weld_result_t expected_welds[$];
    int           mismatch_count;

    // Idling knobs: percent of cycles the sender holds off / the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    // Shadow of the block's state, advanced on every accepted transfer.
    logic [TOL_W-1:0]    tol_shadow;
    coord_t              win_x  [WINDOW_DEPTH];
    coord_t              win_y  [WINDOW_DEPTH];
    coord_t              win_z  [WINDOW_DEPTH];
    logic [ID_WIDTH-1:0] win_id [WINDOW_DEPTH];
    int                  win_fill;
    int                  win_head;
    bit                  run_dropped;
    logic [BUCKET_W-1:0] run_bucket;
    logic [ID_WIDTH-1:0] fresh_id;

    // Stimulus-side memory of the current bucket run, used to aim points near earlier ones.
    point_t              gen_run[$];
    logic [BUCKET_W-1:0] gen_bucket;
    logic [BUCKET_W-1:0] gen_prev_bucket;

    // ------------------------------------------------------------------
    // Clock and the run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("point_fuse_within_tolerance_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Exact per-axis closeness; the difference is taken wide so it never wraps.
    function automatic bit axis_near(coord_t a, coord_t b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d < longint'(tol_shadow);
    endfunction

    function automatic void clear_window();
        win_fill    = 0;
        win_head    = 0;
        run_dropped = 1'b0;
    endfunction

    // Weld one point against the shadow window and queue the result it must produce.
    function automatic void predict_weld(logic first, logic [BUCKET_W-1:0] bucket,
                                         coord_t px, coord_t py, coord_t pz);
        weld_result_t r;
        bit           fused;
        int           slot;
        fused = 1'b0;
        r     = '0;

        // A set start also restarts the ids; a bucket change only empties the window.
        if (first)
        begin
            clear_window();
            fresh_id   = '0;
            run_bucket = bucket;
        end
        else if (bucket != run_bucket)
        begin
            clear_window();
            run_bucket = bucket;
        end

        // Overflow is reported as it stood before this point is compared.
        r.window_overflow = run_dropped;

        // Scan newest first; the first close entry wins.
        for (int k = 1; k <= win_fill; k++)
        begin
            slot = (win_head + WINDOW_DEPTH - k) % WINDOW_DEPTH;
            if (!fused && axis_near(px, win_x[slot]) && axis_near(py, win_y[slot]) &&
                axis_near(pz, win_z[slot]))
            begin
                r.point_id = win_id[slot];
                fused      = 1'b1;
            end
        end

        // Fresh ids saturate at all ones.
        if (!fused)
        begin
            r.point_id = fresh_id;
            if (fresh_id != {ID_WIDTH{1'b1}})
                fresh_id = fresh_id + 1'b1;
        end
        r.is_new = !fused;

        // Every point enters the window, overwriting the oldest once full.
        win_x[win_head]  = px;
        win_y[win_head]  = py;
        win_z[win_head]  = pz;
        win_id[win_head] = r.point_id;
        win_head         = (win_head + 1) % WINDOW_DEPTH;
        if (win_fill < WINDOW_DEPTH)
            win_fill++;
        else
            run_dropped = 1'b1;

        expected_welds.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one point: idle at random, then hold valid until the transfer happens.
    // Valid stays high after the transfer until the next call or a config write
    // drives it, so it is never lowered and raised in the same step.
    task automatic send_point(logic first, logic [BUCKET_W-1:0] bucket,
                              coord_t px, coord_t py, coord_t pz);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            points_if.valid <= 1'b0;
            @(negedge clk);
        end
        points_if.valid        <= 1'b1;
        points_if.first_of_set <= first;
        points_if.bucket_code  <= bucket;
        points_if.x_coord      <= px;
        points_if.y_coord      <= py;
        points_if.z_coord      <= pz;
        do
            @(posedge clk);
        while (points_if.ready !== 1'b1);
        predict_weld(first, bucket, px, py, pz);
    endtask

    // Write the tolerance only once the block has drained and gone idle.
    task automatic set_tolerance(logic [TOL_W-1:0] value);
        @(negedge clk);
        points_if.valid <= 1'b0;
        wait (expected_welds.size() == 0);
        // Let the sequencer settle after the last result leaves.
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we     <= 1'b0;
        tol_shadow  = value;
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    // Receiver: stall at random, one ready update per falling edge.
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking: compare every result transfer with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        weld_result_t exp_r;
        if (rst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1)
        begin
            if (expected_welds.size() == 0)
            begin
                $display("%0t: unexpected result id=%0h is_new=%0b ovf=%0b", $realtime,
                         results_if.point_id, results_if.is_new,
                         results_if.window_overflow);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_welds.pop_front();
                if (results_if.point_id !== exp_r.point_id)
                begin
                    $display("%0t: point_id expected %0h actual %0h", $realtime,
                             exp_r.point_id, results_if.point_id);
                    mismatch_count++;
                end
                if (results_if.is_new !== exp_r.is_new)
                begin
                    $display("%0t: is_new expected %0b actual %0b", $realtime,
                             exp_r.is_new, results_if.is_new);
                    mismatch_count++;
                end
                if (results_if.window_overflow !== exp_r.window_overflow)
                begin
                    $display("%0t: window_overflow expected %0b actual %0b", $realtime,
                             exp_r.window_overflow, results_if.window_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // No set started yet: behave as a set begun at reset on bucket 0. With the
    // reset tolerance of zero even identical points never fuse.
    task automatic test_unstarted_set();
        send_point(1'b0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        send_point(1'b0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        // Bucket change without a set start: window empties, ids keep counting.
        send_point(1'b0, 32'h5, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    endtask

    // Strict less-than on each axis, with points placed at the coordinate extremes.
    task automatic test_tolerance_edge();
        set_tolerance(31'h0001_0000);
        send_point(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        // x differs by exactly the tolerance: must not fuse.
        send_point(1'b0, 32'hFFFF_FFFF, 32'h7FFE_FFFF, 32'h8000_0000, 32'h0);
        // One less than the tolerance on every axis from the newest: fuses.
        send_point(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 32'h8000_FFFF, 32'h0000_FFFF);
    endtask

    // A bucket that comes back after a change never sees its old run.
    task automatic test_bucket_return();
        send_point(1'b1, 32'hA5A5_0001, 32'h100, 32'h200, 32'h300);
        send_point(1'b0, 32'h5A5A_0002, 32'h100, 32'h200, 32'h300);
        send_point(1'b0, 32'hA5A5_0001, 32'h100, 32'h200, 32'h300);
    endtask

    // Fill the window past its depth with far-apart points. The oldest point is
    // dropped, so a copy of it takes a fresh id; a copy of the newest fuses, and
    // both report the overflow.
    task automatic test_window_overflow();
        coord_t c;
        for (int k = 0; k <= WINDOW_DEPTH; k++)
        begin
            c = coord_t'(k << 20);
            send_point(k == 0, 32'h0000_0042, c, -c, c);
        end
        send_point(1'b0, 32'h0000_0042, 32'h0, 32'h0, 32'h0);
        c = coord_t'(WINDOW_DEPTH << 20);
        send_point(1'b0, 32'h0000_0042, c, -c, c);
    endtask

    // Largest tolerance: the full-range difference still does not fuse.
    task automatic test_max_tolerance();
        set_tolerance(31'h7FFF_FFFF);
        send_point(1'b1, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(1'b0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // ------------------------------------------------------------------
    // Random runs
    // ------------------------------------------------------------------

    // Move a coordinate by an offset around the tolerance, often right at the edge.
    function automatic coord_t jitter(coord_t c);
        longint      span;
        longint      off;
        int unsigned pick;
        span = (tol_shadow == 0) ? 3 : longint'(tol_shadow);
        pick = $urandom_range(3);
        case (pick)
            0: off = span;
            1: off = span - 1;
            default: off = longint'($urandom_range(0, 32'(2 * span))) - span;
        endcase
        if (pick < 2 && $urandom_range(1))
            off = -off;
        return coord_t'(longint'(c) + off);
    endfunction

    function automatic coord_t any_coord();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Mostly long bucket runs with points near earlier ones; now and then a new
    // set, a bucket change, or a return to the previous bucket.
    task automatic send_random_point();
        logic                first;
        int unsigned         roll;
        logic [BUCKET_W-1:0] tmp;
        point_t              p;
        point_t              base;
        first = 1'b0;
        roll  = $urandom_range(99);
        if (roll < 4)
        begin
            first = 1'b1;
            if ($urandom_range(1))
                gen_bucket = $urandom;
            gen_run.delete();
        end
        else if (roll < 10)
        begin
            tmp = gen_bucket;
            gen_bucket = ($urandom_range(3) == 0) ? gen_prev_bucket : 32'($urandom);
            gen_prev_bucket = tmp;
            gen_run.delete();
        end

        if (gen_run.size() > 0 && $urandom_range(99) < 60)
        begin
            base = gen_run[$urandom_range(gen_run.size() - 1)];
            p.x  = jitter(base.x);
            p.y  = jitter(base.y);
            p.z  = jitter(base.z);
        end
        else
        begin
            p.x = any_coord();
            p.y = any_coord();
            p.z = any_coord();
        end
        gen_run.push_back(p);
        if (gen_run.size() > 20)
            void'(gen_run.pop_front());

        send_point(first, gen_bucket, p.x, p.y, p.z);
    endtask

    // Sweep tolerance settings, extremes included, cycling through the four idling mixes.
    // The id counter saturation point lies far beyond a run of this length.
    task automatic test_random_runs();
        logic [TOL_W-1:0] tol_set[7];
        tol_set[0] = 31'h0001_0000;
        tol_set[1] = 31'h0;
        tol_set[2] = 31'h1;
        tol_set[3] = 31'h7FFF_FFFF;
        tol_set[4] = 31'h0000_0100;
        tol_set[5] = TOL_W'($urandom_range(0, 32'h7FFF_FFFF));
        tol_set[6] = TOL_W'($urandom_range(0, 32'h00FF_FFFF));
        for (int phase = 0; phase < 7; phase++)
        begin
            set_tolerance(tol_set[phase]);
            set_idling(phase);
            gen_run.delete();
            repeat (RANDOM_ITEMS) send_random_point();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        points_if.valid        = 1'b0;
        points_if.first_of_set = 1'b0;
        points_if.bucket_code  = '0;
        points_if.x_coord      = '0;
        points_if.y_coord      = '0;
        points_if.z_coord      = '0;
        mismatch_count         = 0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        gen_bucket             = '0;
        gen_prev_bucket        = '0;
        tol_shadow             = '0;
        fresh_id               = '0;
        run_bucket             = '0;
        clear_window();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unstarted_set();
        test_tolerance_edge();
        test_bucket_return();
        set_idling(3);
        test_window_overflow();
        test_max_tolerance();
        test_random_runs();

        // Drain, then give the block time to show any stray result.
        @(negedge clk);
        points_if.valid <= 1'b0;
        wait (expected_welds.size() == 0);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("point_fuse_within_tolerance_test: done, clean");
        else
            $display("point_fuse_within_tolerance_test: done, errors");
        $finish;
    end

endmodule
